// File: sv/cmacc_pkg.sv
// ----------------------------------------------------------------------------
// cmacc_pkg
// Shared types and constants of the covariance matrix accumulator.
// ----------------------------------------------------------------------------
package cmacc_pkg;

	localparam int MAX_DIMS_DEF = 128;
	localparam int MAX_ROWS_DEF = 65535;

	localparam int FUNC_W  = 2;
	localparam int VALUE_W = 16;
	localparam int SEL_W   = 7;
	localparam int COV_W   = 32;
	localparam int SUM_W   = 48;
	localparam int ROWS_W  = 16;
	localparam int CFG_W   = 8;
	localparam int PROD_W  = 2 * VALUE_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_ACC,
		ST_READ,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// File: sv/cmacc_req_if.sv
// ----------------------------------------------------------------------------
// cmacc_req_if / cmacc_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface cmacc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [cmacc_pkg::FUNC_W-1:0]         func;
	logic signed [cmacc_pkg::VALUE_W-1:0] value;
	logic [cmacc_pkg::SEL_W-1:0]          row_sel;
	logic [cmacc_pkg::SEL_W-1:0]          col_sel;
	modport source (output valid, func, value, row_sel, col_sel, input ready);
	modport sink   (input valid, func, value, row_sel, col_sel, output ready);
endinterface

interface cmacc_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [cmacc_pkg::COV_W-1:0] cov_value;
	logic                               status;
	modport source (output valid, cov_value, status, input ready);
	modport sink   (input valid, cov_value, status, output ready);
endinterface

// File: sv/cmacc_cell.sv
// ----------------------------------------------------------------------------
// cmacc_cell
// One row buffer element of the shift/rotate chain.
// ----------------------------------------------------------------------------
module cmacc_cell (
	input  logic                                 clk,
	input  logic                                 shift,
	input  logic signed [cmacc_pkg::VALUE_W-1:0] din,
	output logic signed [cmacc_pkg::VALUE_W-1:0] q
);
	import cmacc_pkg::*;

	logic signed [VALUE_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= din;
		end
	end

	assign q = val_q;
endmodule

// File: sv/cmacc_ram.sv
// ----------------------------------------------------------------------------
// cmacc_ram
// Accumulator memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module cmacc_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [AW-1:0]                      wr_addr,
	input  logic signed [cmacc_pkg::SUM_W-1:0] wr_data,
	input  logic                               rd_en,
	input  logic [AW-1:0]                      rd_addr,
	output logic signed [cmacc_pkg::SUM_W-1:0] rd_data
);
	import cmacc_pkg::*;

	logic signed [SUM_W-1:0] mem [DEPTH];
	logic signed [SUM_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

// File: sv/cmacc_div.sv
// ----------------------------------------------------------------------------
// cmacc_div
// Restoring divider: signed sum by unsigned row count, one bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cmacc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cmacc_pkg::SUM_W-1:0]  dividend,
	input  logic [cmacc_pkg::ROWS_W-1:0]        divisor,
	output logic                                done,
	output logic signed [cmacc_pkg::SUM_W-1:0]  quotient
);
	import cmacc_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [ROWS_W-1:0] dvs_q;
	logic [ROWS_W:0]   rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [ROWS_W:0]   rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[ROWS_W-1:0], quo_q[SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// File: sv/covariance_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// covariance_matrix_accumulator
// Sample covariance matrix of standardized Q4.11 rows, read back as Q9.22.
// ----------------------------------------------------------------------------
// Request channel req: func push / read / clear, value, row_sel, col_sel.
// Response channel rsp: one item per read, cov_value and status.
// The user is to write num_dims through cfg_we / cfg_data while the block is
// idle; the block does not enforce it. A push that does not complete a row
// leaves the block idle and ready. The push that completes a row, while fewer
// than MAX_ROWS rows are counted, starts a rotation of the row buffer chain:
// a load state, d*d accumulator updates at one memory read-modify-write per
// cycle, then a write-back, after which the next item is taken. The chain
// cell head feeds the single multiplier. A read passes a memory read, 48
// iterations of the bit-serial divider, saturation and output load (only memory
// read and output load for a known zero result) ahead of rsp.valid and the next item.
// After reset and after every clear, a clearing pass writes zeros to all
// MAX_DIMS*MAX_DIMS accumulator entries, one per cycle (16384 entries at the
// defaults); req.ready stays low meanwhile, config writes still work.
// A result waits in the output register while rsp.ready is low; further
// requests are still taken until a new read result needs that register.
// ----------------------------------------------------------------------------
module covariance_matrix_accumulator #(
	parameter int MAX_DIMS = cmacc_pkg::MAX_DIMS_DEF,
	parameter int MAX_ROWS = cmacc_pkg::MAX_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cmacc_pkg::CFG_W-1:0]  cfg_data,
	cmacc_req_if.sink                    req,
	cmacc_rsp_if.source                  rsp
);
	import cmacc_pkg::*;

	localparam int DEPTH = MAX_DIMS * MAX_DIMS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_DIMS);
	localparam int DW    = $clog2(MAX_DIMS + 1);

	state_t st_q, st_n;

	logic [CFG_W-1:0]  cfg_q;
	logic [DW-1:0]     dims;
	logic [IW-1:0]     dlast;
	logic [DW-1:0]     col_q;
	logic [DW-1:0]     col_cur;
	logic [DW-1:0]     col_nxt;
	logic [ROWS_W-1:0] rows_q;
	logic [AW-1:0]     clr_q;
	logic [IW-1:0]     i_q, j_q;
	logic signed [VALUE_W-1:0] a_q, a_nxt_q;

	logic take, push, rd_req, clr_req, row_done, row_keep, zero_q;
	logic clr_last, acc_last;

	// row buffer chain
	logic signed [VALUE_W-1:0] chain [MAX_DIMS];
	logic signed [VALUE_W-1:0] head;
	logic signed [VALUE_W-1:0] feed;
	logic                      shift;

	// accumulate pipeline
	logic signed [PROD_W-1:0] prod_s1;
	logic [AW-1:0]            addr_s1;
	logic                     wr_s1;

	logic                    ram_we;
	logic [AW-1:0]           ram_wa;
	logic signed [SUM_W-1:0] ram_wd;
	logic                    ram_re;
	logic [AW-1:0]           ram_ra;
	logic signed [SUM_W-1:0] ram_rd;

	logic                    div_start;
	logic                    div_done;
	logic signed [SUM_W-1:0] quo;
	logic signed [COV_W-1:0] res_q;
	logic                    stat_q;

	logic                    ov_q;
	logic signed [COV_W-1:0] cov_q;
	logic                    ost_q;

	// effective row length
	always_comb begin
		if (cfg_q == '0) begin
			dims = DW'(1);
		end else if (32'(cfg_q) > MAX_DIMS) begin
			dims = DW'(MAX_DIMS);
		end else begin
			dims = DW'(cfg_q);
		end
	end
	assign dlast = IW'(dims - 1'b1);

	assign take    = req.valid && req.ready;
	assign push    = take && (req.func == FUNC_PUSH);
	assign rd_req  = take && (req.func == FUNC_READ);
	assign clr_req = take && (req.func == FUNC_CLEAR);

	// a push at or beyond the row length restarts the row
	assign col_cur  = (col_q >= dims) ? '0 : col_q;
	assign col_nxt  = col_cur + 1'b1;
	assign row_done = col_nxt >= dims;
	assign row_keep = rows_q < ROWS_W'(MAX_ROWS);

	assign clr_last = clr_q == AW'(DEPTH - 1);
	assign acc_last = (i_q == dlast) && (j_q == dlast);

	// chain: pushes shift in at cell 0, rotation feeds cell d-1 back to 0
	assign head  = chain[dlast];
	assign shift = push || (st_q == ST_ACC);
	assign feed  = push ? req.value : head;

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
		cmacc_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.din   ((k == 0) ? feed : chain[(k == 0) ? 0 : k - 1]),
			.q     (chain[k])
		);
	end

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_CLEAR: if (clr_last) st_n = ST_IDLE;
			ST_IDLE: begin
				if (push && row_done && row_keep) begin
					st_n = ST_LOAD;
				end else if (rd_req) begin
					st_n = ST_READ;
				end else if (clr_req) begin
					st_n = ST_CLEAR;
				end
			end
			ST_LOAD: st_n = ST_ACC;
			ST_ACC:  if (acc_last) st_n = ST_IDLE;
			ST_READ: st_n = zero_q ? ST_OUT : ST_DIV;
			ST_DIV:  if (div_done) st_n = ST_OUT;
			ST_OUT:  if (!ov_q || rsp.ready) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	// outputs of the control
	always_comb begin
		req.ready = (st_q == ST_IDLE) && !wr_s1;
		div_start = (st_q == ST_READ) && !zero_q;
		ram_re    = (st_q == ST_ACC) || rd_req;
		ram_ra    = (st_q == ST_ACC) ? AW'(AW'(i_q) * AW'(MAX_DIMS) + AW'(j_q))
		                             : AW'(AW'(req.row_sel) * AW'(MAX_DIMS) + AW'(req.col_sel));
		ram_we    = (st_q == ST_CLEAR) || wr_s1;
		ram_wa    = (st_q == ST_CLEAR) ? clr_q : addr_s1;
		ram_wd    = (st_q == ST_CLEAR) ? '0 : ram_rd + SUM_W'(prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			cfg_q  <= CFG_W'(128);
			col_q  <= '0;
			rows_q <= '0;
			clr_q  <= '0;
			i_q    <= '0;
			j_q    <= '0;
			wr_s1  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			st_q  <= st_n;
			wr_s1 <= (st_q == ST_ACC);
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			if (push) begin
				col_q <= row_done ? '0 : col_nxt;
				if (row_done && row_keep) begin
					rows_q <= rows_q + 1'b1;
				end
			end
			if (clr_req) begin
				col_q  <= '0;
				rows_q <= '0;
			end
			if (st_q == ST_LOAD) begin
				i_q <= '0;
				j_q <= '0;
			end else if (st_q == ST_ACC) begin
				if (j_q == dlast) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			// load a new result, else drop the one taken by the receiver
			if ((st_q == ST_OUT) && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD) begin
			a_q <= head;
		end else if (st_q == ST_ACC) begin
			// row[i+1] passes the head during pass i
			if (32'(j_q) == 32'(i_q) + 1) begin
				a_nxt_q <= head;
			end
			if (j_q == dlast) begin
				a_q <= (32'(j_q) == 32'(i_q) + 1) ? head : a_nxt_q;
			end
		end
		prod_s1 <= a_q * head;
		addr_s1 <= ram_ra;
		if (rd_req) begin
			stat_q <= rows_q < ROWS_W'(2);
			zero_q <= (rows_q < ROWS_W'(2)) || (32'(req.row_sel) >= 32'(dims))
			          || (32'(req.col_sel) >= 32'(dims));
		end
		if (st_q == ST_READ) begin
			res_q <= '0;
		end else if (div_done) begin
			if (quo > SUM_W'(signed'(32'h7fff_ffff))) begin
				res_q <= 32'sh7fff_ffff;
			end else if (quo < -SUM_W'(signed'(33'sh0_8000_0000))) begin
				res_q <= 32'sh8000_0000;
			end else begin
				res_q <= COV_W'(quo);
			end
		end
		if ((st_q == ST_OUT) && (!ov_q || rsp.ready)) begin
			cov_q <= res_q;
			ost_q <= stat_q;
		end
	end

	cmacc_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_re),
		.rd_addr (ram_ra),
		.rd_data (ram_rd)
	);

	cmacc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ram_rd),
		.divisor  (rows_q - 1'b1),
		.done     (div_done),
		.quotient (quo)
	);

	assign rsp.valid     = ov_q;
	assign rsp.cov_value = cov_q;
	assign rsp.status    = ost_q;

`ifndef SYNTHESIS
	// an accepted read never races the write-back of an accumulate
	a_no_rmw_race: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s1 && req.valid && req.ready))
		else $error("request accepted during accumulator write-back");

	// divider finishes only while a read is dividing
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV))
		else $error("divider done outside divide state");

	// the row count never passes its limit
	a_rows_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rows_q) <= MAX_ROWS)
		else $error("row count above limit");
`endif
endmodule
